[sv/tnrx_pkg.sv]
// ----------------------------------------------------------------------------
// tnrx_pkg: shared definitions for the Telnet receive option negotiator
// Telnet command codes, option ids, reply verbs, parser states, the result
// record and the table of offers sent at connection start.
// ----------------------------------------------------------------------------
`default_nettype none

package tnrx_pkg;

   // Default number of negotiable options (mask width)
   localparam int DEF_OPTION_COUNT = 32;

   // Telnet command bytes
   localparam logic [7:0] T_IAC  = 8'd255;
   localparam logic [7:0] T_DONT = 8'd254;
   localparam logic [7:0] T_DO   = 8'd253;
   localparam logic [7:0] T_WONT = 8'd252;
   localparam logic [7:0] T_WILL = 8'd251;
   localparam logic [7:0] T_SB   = 8'd250;
   localparam logic [7:0] T_SE   = 8'd240;

   // Option ids we care about
   localparam logic [7:0] OPT_BINARY = 8'd0;
   localparam logic [7:0] OPT_ECHO   = 8'd1;
   localparam logic [7:0] OPT_SGA    = 8'd3;

   // Printable window: first printable byte and first byte past it
   localparam logic [7:0] PRINT_LO = 8'd3;
   localparam logic [7:0] PRINT_HI = 8'd127;

   // Reply verbs
   localparam logic [1:0] V_WILL = 2'd0;
   localparam logic [1:0] V_WONT = 2'd1;
   localparam logic [1:0] V_DO   = 2'd2;
   localparam logic [1:0] V_DONT = 2'd3;

   // Item and result kinds
   localparam logic OP_BYTE    = 1'b0;
   localparam logic OP_CONNECT = 1'b1;
   localparam logic K_DATA     = 1'b0;
   localparam logic K_REPLY    = 1'b1;

   // Connection start emits offers 0..OFFER_LAST
   localparam logic [2:0] OFFER_LAST = 3'd4;

   typedef enum logic [3:0] {
      PS_DATA,
      PS_IAC,
      PS_DONT,
      PS_DO,
      PS_WONT,
      PS_WILL,
      PS_SB_ID,
      PS_SB,
      PS_SB_IAC
   } parse_state_type;

   // One result record
   typedef struct packed {
      logic       kind;
      logic [7:0] data_byte;
      logic [1:0] reply_verb;
      logic [4:0] reply_option;
      logic       last;
   } rsp_type;

   // Item held in the input stage, plus the step strobe
   typedef struct packed {
      logic       step;
      logic       opcode;
      logic [7:0] rx_byte;
      logic [2:0] offer_idx;
   } step_type;

   // Opening offers: WILL SGA, DO SGA, WILL ECHO, WILL BINARY, DO BINARY
   function automatic rsp_type offer_result(input logic [2:0] idx);
      rsp_type r;
      r              = '0;
      r.kind         = K_REPLY;
      r.last         = (idx == OFFER_LAST);
      case (idx)
         3'd0:    begin r.reply_verb = V_WILL; r.reply_option = OPT_SGA[4:0];    end
         3'd1:    begin r.reply_verb = V_DO;   r.reply_option = OPT_SGA[4:0];    end
         3'd2:    begin r.reply_verb = V_WILL; r.reply_option = OPT_ECHO[4:0];   end
         3'd3:    begin r.reply_verb = V_WILL; r.reply_option = OPT_BINARY[4:0]; end
         default: begin r.reply_verb = V_DO;   r.reply_option = OPT_BINARY[4:0]; end
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

[sv/tnrx_parser.sv]
// ----------------------------------------------------------------------------
// tnrx_parser: IAC command parser and option mask tracking
// Holds the parse state, local/remote option masks and binary mode, and
// produces at most one result per step.
// ----------------------------------------------------------------------------
`default_nettype none

module tnrx_parser
   import tnrx_pkg::*;
#(
   parameter int OPTION_COUNT = DEF_OPTION_COUNT
) (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire step_type step_i,
   output rsp_type       res_o,
   output logic          res_valid_o
);

   localparam int IDX_W = $clog2(OPTION_COUNT);

   parse_state_type          ps_ff, ps_in;
   logic [OPTION_COUNT-1:0]  local_ff, local_in;
   logic [OPTION_COUNT-1:0]  remote_ff, remote_in;
   logic                     binary_ff, binary_in;

   logic [7:0]       c;
   logic             opt_ok;
   logic [IDX_W-1:0] opt_idx;
   logic             lbit, rbit;
   logic             printable;
   logic             offer_done;

   assign c          = step_i.rx_byte;
   assign opt_ok     = (c < 8'(OPTION_COUNT));
   assign opt_idx    = c[IDX_W-1:0];
   assign lbit       = opt_ok && local_ff[opt_idx];
   assign rbit       = opt_ok && remote_ff[opt_idx];
   assign printable  = (c >= PRINT_LO) && (c < PRINT_HI);
   assign offer_done = step_i.opcode && (step_i.offer_idx == OFFER_LAST);

   // Next parse state
   always_comb begin
      ps_in = ps_ff;
      if (step_i.step) begin
         if (step_i.opcode == OP_CONNECT) begin
            if (offer_done) ps_in = PS_DATA;
         end else begin
            unique case (ps_ff) inside
               PS_IAC: begin
                  unique case (c)
                     T_DONT:  ps_in = PS_DONT;
                     T_DO:    ps_in = PS_DO;
                     T_WONT:  ps_in = PS_WONT;
                     T_WILL:  ps_in = PS_WILL;
                     T_SB:    ps_in = PS_SB_ID;
                     default: ps_in = PS_DATA;
                  endcase
               end
               PS_DONT, PS_DO, PS_WONT, PS_WILL: ps_in = PS_DATA;
               PS_SB_ID:  ps_in = PS_SB;
               PS_SB:     ps_in = (c == T_IAC) ? PS_SB_IAC : PS_SB;
               PS_SB_IAC: ps_in = (c == T_SE) ? PS_DATA : PS_SB;
               default:   ps_in = (c == T_IAC) ? PS_IAC : PS_DATA;
            endcase
         end
      end
   end

   // Results and mask updates
   always_comb begin
      res_o       = '0;
      res_valid_o = 1'b0;
      local_in    = local_ff;
      remote_in   = remote_ff;
      binary_in   = binary_ff;
      if (step_i.step) begin
         if (step_i.opcode == OP_CONNECT) begin
            res_o       = offer_result(step_i.offer_idx);
            res_valid_o = 1'b1;
            // masks settle to their post-offer values on the final offer
            if (offer_done) begin
               local_in                     = '0;
               local_in[IDX_W'(OPT_SGA)]    = 1'b1;
               local_in[IDX_W'(OPT_ECHO)]   = 1'b1;
               local_in[IDX_W'(OPT_BINARY)] = 1'b1;
               remote_in                    = '0;
               remote_in[IDX_W'(OPT_SGA)]   = 1'b1;
               remote_in[IDX_W'(OPT_BINARY)] = 1'b1;
               binary_in                    = 1'b0;
            end
         end else begin
            res_o.reply_option = c[4:0];
            res_o.last         = 1'b1;
            unique case (ps_ff) inside
               PS_IAC: begin
                  // escaped IAC is data, only in binary mode
                  if (c == T_IAC && binary_ff) begin
                     res_o.kind         = K_DATA;
                     res_o.data_byte    = c;
                     res_o.reply_option = '0;
                     res_valid_o        = 1'b1;
                  end
               end
               PS_DONT: begin
                  if (lbit) begin
                     local_in[opt_idx] = 1'b0;
                     res_o.kind        = K_REPLY;
                     res_o.reply_verb  = V_WONT;
                     res_valid_o       = 1'b1;
                  end
               end
               PS_DO: begin
                  if (c == OPT_SGA || c == OPT_ECHO || c == OPT_BINARY) begin
                     if (!lbit) begin
                        local_in[opt_idx] = 1'b1;
                        res_o.kind        = K_REPLY;
                        res_o.reply_verb  = V_WILL;
                        res_valid_o       = 1'b1;
                     end
                  end else if (lbit) begin
                     local_in[opt_idx] = 1'b0;
                     res_o.kind        = K_REPLY;
                     res_o.reply_verb  = V_WONT;
                     res_valid_o       = 1'b1;
                  end
               end
               PS_WONT: begin
                  if (rbit) begin
                     remote_in[opt_idx] = 1'b0;
                     res_o.kind         = K_REPLY;
                     res_o.reply_verb   = V_DONT;
                     res_valid_o        = 1'b1;
                  end
               end
               PS_WILL: begin
                  if (c == OPT_SGA || c == OPT_BINARY) begin
                     if (c == OPT_BINARY) binary_in = 1'b1;
                     if (!rbit) begin
                        remote_in[opt_idx] = 1'b1;
                        res_o.kind         = K_REPLY;
                        res_o.reply_verb   = V_DO;
                        res_valid_o        = 1'b1;
                     end
                  end else if (rbit) begin
                     remote_in[opt_idx] = 1'b0;
                     res_o.kind         = K_REPLY;
                     res_o.reply_verb   = V_DONT;
                     res_valid_o        = 1'b1;
                  end
               end
               PS_SB_ID, PS_SB, PS_SB_IAC: begin
                  res_o.reply_option = '0;
               end
               default: begin
                  // data state: forward printable bytes, or all but IAC in binary mode
                  res_o.reply_option = '0;
                  if (c != T_IAC && (binary_ff || printable)) begin
                     res_o.kind      = K_DATA;
                     res_o.data_byte = c;
                     res_valid_o     = 1'b1;
                  end
               end
            endcase
         end
      end
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         ps_ff     <= PS_DATA;
         local_ff  <= '0;
         remote_ff <= '0;
         binary_ff <= 1'b0;
      end else begin
         ps_ff     <= ps_in;
         local_ff  <= local_in;
         remote_ff <= remote_in;
         binary_ff <= binary_in;
      end
   end

endmodule

`default_nettype wire

[sv/tnrx_outreg.sv]
// ----------------------------------------------------------------------------
// tnrx_outreg: result register
// Holds one result transaction until the downstream side takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module tnrx_outreg
   import tnrx_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    load_i,
   input  wire rsp_type res_i,
   input  wire logic    rsp_tready,
   output logic         rsp_tvalid,
   output rsp_type      rsp_o,
   output logic         free_o
);

   logic    valid_ff, valid_in;
   rsp_type res_ff, res_in;

   // Register can take a new result when empty or being drained
   assign free_o = !valid_ff || rsp_tready;

   always_comb begin
      valid_in = valid_ff;
      res_in   = res_ff;
      if (load_i) begin
         valid_in = 1'b1;
         res_in   = res_i;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else       valid_ff <= valid_in;
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_o      = res_ff;

endmodule

`default_nettype wire

[sv/telnet_rx_option_negotiator_top.sv]
// A received byte's result passes the input and result registers. One byte is
// taken per cycle while the result register is free; a connection start holds
// the input stage while the offer counter steps through its 5 replies.
// A byte that causes no result still occupies a parser step.
// Reset (synchronous, active high) empties both registers and returns the
// parser to the data state with both option masks and binary mode cleared.
// ----------------------------------------------------------------------------
// telnet_rx_option_negotiator_top: Telnet receive option negotiator
// Input register and offer counter, IAC parser, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module telnet_rx_option_negotiator_top
   import tnrx_pkg::*;
#(
   parameter int OPTION_COUNT = DEF_OPTION_COUNT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] rx_byte
   input  wire logic        req_tuser,   // [0] opcode
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,   // [7:0] data_byte, [9:8] reply_verb,
                                         // [14:10] reply_option, [15] zero
   output logic             rsp_tuser,   // [0] kind
   output logic             rsp_tlast    // last result of the item
);

   logic       in_valid_ff, in_valid_in;
   logic       in_op_ff, in_op_in;
   logic [7:0] in_byte_ff, in_byte_in;
   logic [2:0] offer_cnt_ff, offer_cnt_in;

   logic     out_free;
   logic     advance;
   logic     item_done;
   step_type step;
   rsp_type  res;
   logic     res_valid;
   rsp_type  rsp;

   // Pipeline control
   assign advance    = in_valid_ff && out_free;
   assign item_done  = advance && (!in_op_ff || offer_cnt_ff == OFFER_LAST);
   assign req_tready = !in_valid_ff || item_done;

   // Input register and offer counter
   always_comb begin
      in_valid_in  = in_valid_ff;
      in_op_in     = in_op_ff;
      in_byte_in   = in_byte_ff;
      offer_cnt_in = offer_cnt_ff;
      if (item_done) begin
         in_valid_in  = 1'b0;
         offer_cnt_in = '0;
      end else if (advance) begin
         offer_cnt_in = offer_cnt_ff + 3'd1;
      end
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
         in_op_in    = req_tuser;
         in_byte_in  = req_tdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         offer_cnt_ff <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         offer_cnt_ff <= offer_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      in_op_ff   <= in_op_in;
      in_byte_ff <= in_byte_in;
   end

   assign step.step      = advance;
   assign step.opcode    = in_op_ff;
   assign step.rx_byte   = in_byte_ff;
   assign step.offer_idx = offer_cnt_ff;

   tnrx_parser #(
      .OPTION_COUNT(OPTION_COUNT)
   ) u_parser (
      .clock       (clock),
      .reset       (reset),
      .step_i      (step),
      .res_o       (res),
      .res_valid_o (res_valid)
   );

   tnrx_outreg u_outreg (
      .clock      (clock),
      .reset      (reset),
      .load_i     (advance && res_valid),
      .res_i      (res),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_o      (rsp),
      .free_o     (out_free)
   );

   // Output packing
   assign rsp_tdata = {1'b0, rsp.reply_option, rsp.reply_verb, rsp.data_byte};
   assign rsp_tuser = rsp.kind;
   assign rsp_tlast = rsp.last;

   // Checks
   a_offer_range: assert property (@(posedge clock) disable iff (reset)
      offer_cnt_ff <= OFFER_LAST)
      else $error("offer counter out of range");

   a_offer_owner: assert property (@(posedge clock) disable iff (reset)
      offer_cnt_ff != '0 |-> in_valid_ff && in_op_ff)
      else $error("offer counter running without a connection item");

   a_offer_last: assert property (@(posedge clock) disable iff (reset)
      item_done && in_op_ff |=> rsp_tvalid && rsp_tlast && rsp_tuser)
      else $error("final offer not presented with tlast");

endmodule

`default_nettype wire
